// ===== hdl/lob_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_pkg
// Shared types and constants of the limit order book matcher.
// ----------------------------------------------------------------------------
package lob_pkg;

   // default book geometry
   localparam int LOB_LADDER_SLOTS     = 256;
   localparam int LOB_ORDERS_PER_LEVEL = 8;

   // slots covered by one group of the best-level search
   localparam int LOB_GROUP_SIZE = 16;
   localparam int LOB_GROUP_BITS = 4;

   // order side codes
   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   typedef enum logic [1:0] {
      ST_FILLED = 2'd0,
      ST_RESTED = 2'd1,
      ST_WINDOW = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef struct packed {
      logic        side;
      logic [31:0] price;
      logic [31:0] quantity;
      logic [31:0] reference;
   } lob_order_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] buyer_reference;
      logic [31:0] seller_reference;
      logic [31:0] fill_price;
      logic [31:0] fill_quantity;
   } lob_result_type;

   typedef enum logic [3:0] {
      E_IDLE,
      E_GROUP,
      E_SLOT,
      E_OPP_RD,
      E_OPP_CHK,
      E_FILL,
      E_OWN_RD,
      E_OWN_CHK,
      E_SEND
   } eng_state_type;

endpackage

// ===== hdl/lob_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_req_if / lob_rsp_if
// Valid/ready channels for incoming orders and for match results.
// ----------------------------------------------------------------------------
interface lob_req_if;
   logic        valid;
   logic        ready;
   logic        order_side;
   logic [31:0] order_price;
   logic [31:0] order_quantity;
   logic [31:0] order_reference;

   modport source (output valid, output order_side, output order_price,
                   output order_quantity, output order_reference, input ready);
   modport sink   (input valid, input order_side, input order_price,
                   input order_quantity, input order_reference, output ready);
endinterface

interface lob_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] buyer_reference;
   logic [31:0] seller_reference;
   logic [31:0] fill_price;
   logic [31:0] fill_quantity;

   modport source (output valid, output status, output buyer_reference,
                   output seller_reference, output fill_price,
                   output fill_quantity, input ready);
   modport sink   (input valid, input status, input buyer_reference,
                   input seller_reference, input fill_price,
                   input fill_quantity, output ready);
endinterface

// ===== hdl/lob_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lob_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             write_enable,
   input  logic [AddrW-1:0] write_address,
   input  logic [WIDTH-1:0] write_data,
   input  logic [AddrW-1:0] read_address,
   output logic [WIDTH-1:0] read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

// ===== hdl/lob_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_front
// Accepts orders, checks the price window and queues them for the engine.
// ----------------------------------------------------------------------------
module lob_front
   import lob_pkg::*;
#(
   parameter int LADDER_SLOTS = LOB_LADDER_SLOTS,
   localparam int SlotW = $clog2(LADDER_SLOTS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [31:0]        csr_write_data,
   lob_req_if.sink            req_ch,
   output logic               q_valid,
   input  logic               q_ready,
   output lob_order_type      q_order,
   output logic [SlotW-1:0]   q_slot,
   output logic               q_in_window
);

   logic [31:0]      base_price_ff;
   lob_order_type    q_order_ff  [2];
   logic [SlotW-1:0] q_slot_ff   [2];
   logic             q_win_ff    [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   logic             push;
   logic             pop;
   logic [31:0]      offset;
   logic             in_window;

   // hold base price
   always_ff @(posedge clock) begin
      if (reset) begin
         base_price_ff <= '0;
      end else if (csr_write_enable) begin
         base_price_ff <= csr_write_data;
      end
   end

   // classify against the price window
   always_comb begin
      offset    = req_ch.order_price - base_price_ff;
      in_window = (req_ch.order_price >= base_price_ff) &&
                  (offset < 32'(LADDER_SLOTS));
   end

   assign req_ch.ready = (count_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign pop          = q_valid && q_ready;

   // advance queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the classified transaction
   always_ff @(posedge clock) begin
      if (push) begin
         q_order_ff[wr_ptr_ff] <= '{side:      req_ch.order_side,
                                    price:     req_ch.order_price,
                                    quantity:  req_ch.order_quantity,
                                    reference: req_ch.order_reference};
         q_slot_ff[wr_ptr_ff]  <= offset[SlotW-1:0];
         q_win_ff[wr_ptr_ff]   <= in_window;
      end
   end

   assign q_valid     = (count_ff != 2'd0);
   assign q_order     = q_order_ff[rd_ptr_ff];
   assign q_slot      = q_slot_ff[rd_ptr_ff];
   assign q_in_window = q_win_ff[rd_ptr_ff];

endmodule

// ===== hdl/lob_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_engine
// Matches one queued order against the book, rests it or rejects it, and emits a result.
// ----------------------------------------------------------------------------
module lob_engine
   import lob_pkg::*;
#(
   parameter int LADDER_SLOTS     = LOB_LADDER_SLOTS,
   parameter int ORDERS_PER_LEVEL = LOB_ORDERS_PER_LEVEL,
   localparam int SlotW = $clog2(LADDER_SLOTS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_ready,
   input  lob_order_type    q_order,
   input  logic [SlotW-1:0] q_slot,
   input  logic             q_in_window,
   lob_rsp_if.source        rsp_ch
);

   localparam int PosW    = (ORDERS_PER_LEVEL > 1) ? $clog2(ORDERS_PER_LEVEL) : 1;
   localparam int CntW    = $clog2(ORDERS_PER_LEVEL + 1);
   localparam int SumW    = CntW + 1;
   localparam int NumGrp  = (LADDER_SLOTS + LOB_GROUP_SIZE - 1) / LOB_GROUP_SIZE;
   localparam int GrpW    = (NumGrp > 1) ? $clog2(NumGrp) : 1;
   localparam int MetaW   = 32 + PosW + CntW;
   localparam int MetaAW  = 1 + SlotW;
   localparam int EntAW   = 1 + SlotW + PosW;
   localparam int MetaDep = 2 ** MetaAW;
   localparam int EntDep  = 2 ** EntAW;

   eng_state_type        state_ff, state_in;
   lob_order_type        order_ff, order_in;
   logic [SlotW-1:0]     slot_ff, slot_in;
   logic [LADDER_SLOTS-1:0] bid_occ_ff, bid_occ_in;
   logic [LADDER_SLOTS-1:0] ask_occ_ff, ask_occ_in;
   logic [GrpW-1:0]      grp_ff, grp_in;
   logic                 grp_any_ff, grp_any_in;
   logic [SlotW-1:0]     best_ff, best_in;
   logic                 found_ff, found_in;
   logic [31:0]          lvl_price_ff, lvl_price_in;
   logic [PosW-1:0]      head_ff, head_in;
   logic [CntW-1:0]      count_ff, count_in;
   lob_result_type       res_ff, res_in;
   lob_result_type       rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 is_buy;
   logic [NumGrp*LOB_GROUP_SIZE-1:0] opp_bits;
   logic [NumGrp-1:0]    grp_any;
   logic [GrpW-1:0]      grp_sel;
   logic [LOB_GROUP_SIZE-1:0] grp_bits;
   logic [LOB_GROUP_BITS-1:0] bit_sel;
   logic [GrpW+LOB_GROUP_BITS-1:0] best_full;

   logic                 meta_we, ent_we;
   logic [MetaAW-1:0]    meta_waddr, meta_raddr;
   logic [MetaW-1:0]     meta_wdata, meta_rdata;
   logic [EntAW-1:0]     ent_waddr, ent_raddr;
   logic [63:0]          ent_wdata, ent_rdata;

   logic [31:0]          rd_price;
   logic [PosW-1:0]      rd_head;
   logic [CntW-1:0]      rd_count;
   logic                 crossed;
   logic                 own_occ;
   logic [PosW-1:0]      own_head;
   logic [CntW-1:0]      own_count;
   logic                 own_full;
   logic [SumW-1:0]      tail_sum;
   logic [PosW-1:0]      tail_pos;
   logic [31:0]          head_ref, head_qty, fill_qty, left_qty;
   logic [PosW-1:0]      head_next;
   logic                 rsp_free;

   assign is_buy   = (order_ff.side == SIDE_BUY);
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // best-level search over the opposite side's occupancy
   always_comb begin
      opp_bits = '0;
      opp_bits[LADDER_SLOTS-1:0] = is_buy ? ask_occ_ff : bid_occ_ff;
      for (int g = 0; g < NumGrp; g++) begin
         grp_any[g] = |opp_bits[g*LOB_GROUP_SIZE +: LOB_GROUP_SIZE];
      end
      grp_sel = '0;
      if (is_buy) begin
         for (int g = NumGrp - 1; g >= 0; g--) begin
            if (grp_any[g]) grp_sel = GrpW'(g);
         end
      end else begin
         for (int g = 0; g < NumGrp; g++) begin
            if (grp_any[g]) grp_sel = GrpW'(g);
         end
      end
      grp_bits = opp_bits[grp_ff*LOB_GROUP_SIZE +: LOB_GROUP_SIZE];
      bit_sel  = '0;
      if (is_buy) begin
         for (int b = LOB_GROUP_SIZE - 1; b >= 0; b--) begin
            if (grp_bits[b]) bit_sel = LOB_GROUP_BITS'(b);
         end
      end else begin
         for (int b = 0; b < LOB_GROUP_SIZE; b++) begin
            if (grp_bits[b]) bit_sel = LOB_GROUP_BITS'(b);
         end
      end
      best_full = {grp_ff, bit_sel};
   end

   // decode level metadata and entries
   always_comb begin
      {rd_price, rd_head, rd_count} = meta_rdata;
      {head_ref, head_qty}          = ent_rdata;
      crossed = is_buy ? (rd_price <= order_ff.price) : (rd_price >= order_ff.price);
      own_occ   = is_buy ? bid_occ_ff[slot_ff] : ask_occ_ff[slot_ff];
      own_head  = own_occ ? rd_head  : '0;
      own_count = own_occ ? rd_count : '0;
      own_full  = (own_count >= CntW'(ORDERS_PER_LEVEL));
      tail_sum  = SumW'(own_head) + SumW'(own_count);
      if (tail_sum >= SumW'(ORDERS_PER_LEVEL)) begin
         tail_sum = tail_sum - SumW'(ORDERS_PER_LEVEL);
      end
      tail_pos  = tail_sum[PosW-1:0];
      fill_qty  = (order_ff.quantity < head_qty) ? order_ff.quantity : head_qty;
      left_qty  = head_qty - fill_qty;
      head_next = (head_ff == PosW'(ORDERS_PER_LEVEL - 1)) ? '0 : head_ff + 1'b1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         E_IDLE: begin
            if (q_valid) state_in = q_in_window ? E_GROUP : E_SEND;
         end
         E_GROUP:   state_in = E_SLOT;
         E_SLOT:    state_in = E_OPP_RD;
         E_OPP_RD:  state_in = found_ff ? E_OPP_CHK : E_OWN_RD;
         E_OPP_CHK: state_in = crossed ? E_FILL : E_OWN_RD;
         E_FILL:    state_in = E_SEND;
         E_OWN_RD:  state_in = E_OWN_CHK;
         E_OWN_CHK: state_in = E_SEND;
         E_SEND: begin
            if (rsp_free) state_in = E_IDLE;
         end
         default:   state_in = E_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      order_in     = order_ff;
      slot_in      = slot_ff;
      grp_in       = grp_ff;
      grp_any_in   = grp_any_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      lvl_price_in = lvl_price_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      bid_occ_in   = bid_occ_ff;
      ask_occ_in   = ask_occ_ff;
      q_ready      = 1'b0;
      meta_we      = 1'b0;
      meta_waddr   = {~order_ff.side, best_ff};
      meta_wdata   = {lvl_price_ff, head_next, count_ff - 1'b1};
      meta_raddr   = {~order_ff.side, best_ff};
      ent_we       = 1'b0;
      ent_waddr    = {~order_ff.side, best_ff, head_ff};
      ent_wdata    = {head_ref, left_qty};
      ent_raddr    = {~order_ff.side, best_ff, rd_head};
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      case (state_ff)
         E_IDLE: begin
            q_ready  = 1'b1;
            order_in = q_order;
            slot_in  = q_slot;
            res_in   = '{status: ST_WINDOW, default: '0};
         end
         E_GROUP: begin
            grp_in     = grp_sel;
            grp_any_in = |grp_any;
         end
         E_SLOT: begin
            best_in  = best_full[SlotW-1:0];
            found_in = grp_any_ff;
         end
         E_OPP_RD: begin
            meta_raddr = found_ff ? {~order_ff.side, best_ff} : {order_ff.side, slot_ff};
         end
         E_OPP_CHK: begin
            // latch level and read the oldest resting order
            lvl_price_in = rd_price;
            head_in      = rd_head;
            count_in     = rd_count;
            meta_raddr   = {order_ff.side, slot_ff};
         end
         E_FILL: begin
            res_in.status           = ST_FILLED;
            res_in.buyer_reference  = is_buy ? order_ff.reference : head_ref;
            res_in.seller_reference = is_buy ? head_ref : order_ff.reference;
            res_in.fill_price       = lvl_price_ff;
            res_in.fill_quantity    = fill_qty;
            if (left_qty != '0) begin
               ent_we = 1'b1;
            end else begin
               // pop the exhausted head
               meta_we = 1'b1;
               if (count_ff == CntW'(1)) begin
                  if (is_buy) ask_occ_in[best_ff] = 1'b0;
                  else        bid_occ_in[best_ff] = 1'b0;
               end
            end
         end
         E_OWN_RD: begin
            meta_raddr = {order_ff.side, slot_ff};
         end
         E_OWN_CHK: begin
            if (own_full) begin
               res_in.status = ST_FULL;
            end else begin
               // append at the level's tail
               res_in.status = ST_RESTED;
               ent_we        = 1'b1;
               ent_waddr     = {order_ff.side, slot_ff, tail_pos};
               ent_wdata     = {order_ff.reference, order_ff.quantity};
               meta_we       = 1'b1;
               meta_waddr    = {order_ff.side, slot_ff};
               meta_wdata    = {order_ff.price, own_head, own_count + 1'b1};
               if (is_buy) bid_occ_in[slot_ff] = 1'b1;
               else        ask_occ_in[slot_ff] = 1'b1;
            end
         end
         E_SEND: begin
            if (rsp_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= E_IDLE;
         bid_occ_ff   <= '0;
         ask_occ_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bid_occ_ff   <= bid_occ_in;
         ask_occ_ff   <= ask_occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      order_ff     <= order_in;
      slot_ff      <= slot_in;
      grp_ff       <= grp_in;
      grp_any_ff   <= grp_any_in;
      best_ff      <= best_in;
      found_ff     <= found_in;
      lvl_price_ff <= lvl_price_in;
      head_ff      <= head_in;
      count_ff     <= count_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   // level metadata: price, head position, count
   lob_ram #(.WIDTH(MetaW), .DEPTH(MetaDep)) u_meta_ram (
      .clock         (clock),
      .write_enable  (meta_we),
      .write_address (meta_waddr),
      .write_data    (meta_wdata),
      .read_address  (meta_raddr),
      .read_data     (meta_rdata)
   );

   // resting orders: reference, quantity
   lob_ram #(.WIDTH(64), .DEPTH(EntDep)) u_entry_ram (
      .clock         (clock),
      .write_enable  (ent_we),
      .write_address (ent_waddr),
      .write_data    (ent_wdata),
      .read_address  (ent_raddr),
      .read_data     (ent_rdata)
   );

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.status           = rsp_ff.status;
   assign rsp_ch.buyer_reference  = rsp_ff.buyer_reference;
   assign rsp_ch.seller_reference = rsp_ff.seller_reference;
   assign rsp_ch.fill_price       = rsp_ff.fill_price;
   assign rsp_ch.fill_quantity    = rsp_ff.fill_quantity;

endmodule

// ===== hdl/limit_order_book_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Limit order book with one fill per incoming order, or resting it in place.
// ----------------------------------------------------------------------------
// Orders enter on req_ch (valid/ready); one result per order leaves on rsp_ch.
// csr_write_enable/csr_write_data load base_price, the price of ladder slot 0;
// write it only while no order is in flight.
// The front checks the price window and queues up to two orders; the engine
// takes one order at a time from that queue.
// Engine states per order: IDLE, SEND for an out-of-window drop; IDLE,
// GROUP, SLOT, OPP_RD, OPP_CHK, FILL, SEND for a fill. To rest with an
// empty opposite side OPP_RD goes to OWN_RD, OWN_CHK, SEND, and OPP_CHK does
// so when the best opposite level does not cross. The two registered reads
// of the metadata and order RAMs and the two-stage best-level search set them.
// Reset empties the book (occupancy flops cleared at once, no RAM sweep) and
// sets base_price to 0. A stalled rsp_ch holds the result in the output
// register; the engine then waits and the front keeps filling its queue.
// ----------------------------------------------------------------------------
module limit_order_book_matcher
   import lob_pkg::*;
#(
   parameter int LADDER_SLOTS     = LOB_LADDER_SLOTS,
   parameter int ORDERS_PER_LEVEL = LOB_ORDERS_PER_LEVEL
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   lob_req_if.sink     req_ch,
   lob_rsp_if.source   rsp_ch
);

   localparam int SlotW = $clog2(LADDER_SLOTS);

   logic             q_valid;
   logic             q_ready;
   lob_order_type    q_order;
   logic [SlotW-1:0] q_slot;
   logic             q_in_window;

   lob_front #(.LADDER_SLOTS(LADDER_SLOTS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .q_valid          (q_valid),
      .q_ready          (q_ready),
      .q_order          (q_order),
      .q_slot           (q_slot),
      .q_in_window      (q_in_window)
   );

   lob_engine #(
      .LADDER_SLOTS     (LADDER_SLOTS),
      .ORDERS_PER_LEVEL (ORDERS_PER_LEVEL)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_order     (q_order),
      .q_slot      (q_slot),
      .q_in_window (q_in_window),
      .rsp_ch      (rsp_ch)
   );

endmodule

// ===== tb/sv/limit_order_book_matcher_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher_test
// Self-checking bench for the order book matcher. Orders are driven on the
// request channel and every result is compared with a behavioral book model
// kept in the bench, under several base prices and random handshake gaps.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_test;
   import lob_pkg::*;

   localparam int SLOTS = LOB_LADDER_SLOTS;
   localparam int DEPTH = LOB_ORDERS_PER_LEVEL;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;

   lob_req_if req_ch ();
   lob_rsp_if rsp_ch ();

   limit_order_book_matcher u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch.sink),
      .rsp_ch           (rsp_ch.source)
   );

   // book model: one ladder per side
   logic [31:0] book_ref   [2][SLOTS][DEPTH];
   logic [31:0] book_qty   [2][SLOTS][DEPTH];
   int          book_count [2][SLOTS];
   logic [31:0] book_price [2][SLOTS];
   logic [31:0] base_model;

   lob_result_type pending_results[$];
   int  mismatches;
   int  sent_orders;
   int  got_results;
   int  fills_seen;
   int  hold_cycles;
   bit  rsp_hold;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // apply one order to the model book and queue its result
   task automatic predict_order(input lob_order_type ord);
      lob_result_type res;
      int own, opp, slot, best, i;
      logic [31:0] lvl, head_q, fq;
      bit crossed;
      res = '0;
      own = int'(ord.side);
      opp = 1 - own;
      best = -1;
      if (ord.price < base_model || ord.price - base_model >= SLOTS) begin
         res.status = ST_WINDOW;
      end else begin
         slot = int'(ord.price - base_model);
         if (ord.side == SIDE_BUY) begin
            for (i = SLOTS - 1; i >= 0; i--) if (book_count[opp][i] != 0) best = i;
         end else begin
            for (i = 0; i < SLOTS; i++) if (book_count[opp][i] != 0) best = i;
         end
         crossed = 1'b0;
         if (best >= 0) begin
            lvl = book_price[opp][best];
            crossed = (ord.side == SIDE_BUY) ? (lvl <= ord.price) : (lvl >= ord.price);
         end
         if (crossed) begin
            head_q = book_qty[opp][best][0];
            fq = (ord.quantity < head_q) ? ord.quantity : head_q;
            res.status = ST_FILLED;
            res.buyer_reference  = (ord.side == SIDE_BUY) ? ord.reference
                                                          : book_ref[opp][best][0];
            res.seller_reference = (ord.side == SIDE_BUY) ? book_ref[opp][best][0]
                                                          : ord.reference;
            res.fill_price    = lvl;
            res.fill_quantity = fq;
            book_qty[opp][best][0] = head_q - fq;
            if (book_qty[opp][best][0] == 0) begin
               for (i = 0; i + 1 < book_count[opp][best]; i++) begin
                  book_ref[opp][best][i] = book_ref[opp][best][i + 1];
                  book_qty[opp][best][i] = book_qty[opp][best][i + 1];
               end
               book_count[opp][best]--;
            end
         end else if (book_count[own][slot] >= DEPTH) begin
            res.status = ST_FULL;
         end else begin
            book_ref[own][slot][book_count[own][slot]] = ord.reference;
            book_qty[own][slot][book_count[own][slot]] = ord.quantity;
            book_price[own][slot] = ord.price;
            book_count[own][slot]++;
            res.status = ST_RESTED;
         end
      end
      pending_results.push_back(res);
   endtask

   // offer one order after a random gap and wait for acceptance
   task automatic send_order(input logic side, input logic [31:0] price,
                             input logic [31:0] qty, input logic [31:0] ref_id);
      lob_order_type ord;
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      // drop valid only for a real gap, keep it up back to back
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      ord.side = side; ord.price = price; ord.quantity = qty; ord.reference = ref_id;
      req_ch.valid           <= 1'b1;
      req_ch.order_side      <= side;
      req_ch.order_price     <= price;
      req_ch.order_quantity  <= qty;
      req_ch.order_reference <= ref_id;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_order(ord);
      sent_orders++;
      @(negedge clock);
   endtask

   // wait for all results, then let the engine settle
   task automatic drain_book;
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_base(input logic [31:0] value);
      drain_book();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      base_model = value;
   endtask

   function automatic logic [31:0] rand_qty();
      case ($urandom_range(0, 3))
         0: return $urandom_range(1, 4);
         1: return $urandom_range(1, 100);
         2: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // extremes, full level, zero quantity, window edges
   task automatic test_directed;
      int k;
      write_base(32'd1000);
      send_order(SIDE_BUY, 32'd999, 32'd5, 32'h1);
      send_order(SIDE_SELL, 32'd1000 + SLOTS, 32'd5, 32'h2);
      send_order(SIDE_BUY, 32'hFFFF_FFFF, 32'd5, 32'h3);
      for (k = 0; k < DEPTH + 1; k++)
         send_order(SIDE_BUY, 32'd1000, 32'd7 + k, 32'hA000 + k);
      send_order(SIDE_SELL, 32'd1000 + SLOTS - 1, 32'd1, 32'hFFFF_FFFF);
      send_order(SIDE_SELL, 32'd1000, 32'd0, 32'hB0);
      send_order(SIDE_SELL, 32'd1000, 32'hFFFF_FFFF, 32'hB1);
      send_order(SIDE_BUY, 32'd1000 + SLOTS - 1, 32'hFFFF_FFFF, 32'h0);
      send_order(SIDE_BUY, 32'd1000 + SLOTS - 1, 32'd3, 32'hC1);
      // level keeps its old price after a base change
      write_base(32'd990);
      send_order(SIDE_SELL, 32'd990, 32'd2, 32'hD0);
      send_order(SIDE_SELL, 32'd990, 32'd2, 32'hD1);
   endtask

   // random trading around a base
   task automatic test_random(input int count, input int span);
      int k;
      logic [31:0] p;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(0, 19) == 0) p = $urandom;
         else p = base_model + $urandom_range(0, span - 1) - ($urandom_range(0, 15) == 0);
         send_order(1'($urandom_range(0, 1)), p, rand_qty(), $urandom);
      end
   endtask

   // receiver holds off while orders keep coming
   task automatic test_backpressure;
      rsp_hold = 1'b1;
      fork
         test_random(12, 8);
         begin
            hold_cycles = 0;
            while (hold_cycles < 200) begin
               @(posedge clock);
               hold_cycles++;
            end
            rsp_hold = 1'b0;
         end
      join
   endtask

   // result side: random stalls, compare at the rising edge
   initial begin
      int wait_cycles;
      lob_result_type exp_res;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         wait_cycles = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
         // drop ready only when stalling
         if (wait_cycles != 0 || rsp_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
            while (rsp_hold) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         got_results++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result status %0d", rsp_ch.status);
         end else begin
            exp_res = pending_results.pop_front();
            if (exp_res.status == ST_FILLED) fills_seen++;
            if (rsp_ch.status != exp_res.status
                || rsp_ch.buyer_reference != exp_res.buyer_reference
                || rsp_ch.seller_reference != exp_res.seller_reference
                || rsp_ch.fill_price != exp_res.fill_price
                || rsp_ch.fill_quantity != exp_res.fill_quantity) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp %0d %h %h %h %h got %0d %h %h %h %h",
                     exp_res.status, exp_res.buyer_reference,
                     exp_res.seller_reference, exp_res.fill_price,
                     exp_res.fill_quantity, rsp_ch.status, rsp_ch.buyer_reference,
                     rsp_ch.seller_reference, rsp_ch.fill_price, rsp_ch.fill_quantity);
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("limit_order_book_matcher_test NOT OK");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.order_side = 1'b0;
      req_ch.order_price = '0;
      req_ch.order_quantity = '0;
      req_ch.order_reference = '0;
      rsp_hold = 1'b0;
      mismatches = 0; sent_orders = 0; got_results = 0; fills_seen = 0;
      base_model = '0;
      foreach (book_count[s, i]) book_count[s][i] = 0;
      foreach (book_price[s, i]) book_price[s][i] = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      test_random(30, 300);
      test_directed();
      test_backpressure();
      write_base(32'd5000);
      test_random(600, 12);
      write_base(32'hFFFF_FF00);
      test_random(400, 256);
      write_base(32'hFFFF_FFFF);
      test_random(100, 2);
      write_base(32'd0);
      test_random(650, 40);
      drain_book();
      $display("orders sent %0d, results checked %0d, fills %0d, mismatches %0d",
               sent_orders, got_results, fills_seen, mismatches);
      $display("covered window drops, full levels, zero fills and base changes");
      if (mismatches == 0) $display("limit_order_book_matcher_test OK");
      else $display("limit_order_book_matcher_test NOT OK");
      $finish;
   end
endmodule
